// ----- src/tnvt_pkg.sv -----
// Package: types, byte codes and helpers for the telnet NVT receive parser.
`timescale 1ns / 1ps
`default_nettype none
package tnvt_pkg;

  // Line limit and the column widths that follow from it
  localparam int LINE_LENGTH = 256;
  localparam int COL_W       = $clog2(LINE_LENGTH);
  localparam int LEN_W       = COL_W + 1;
  localparam int POS_W       = 9;

  // Result queue
  localparam int FIFO_DEPTH  = 4;
  localparam int FIFO_AW     = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW     = FIFO_AW + 1;

  // Plain text bytes
  localparam logic [7:0] CH_NUL    = 8'd0;
  localparam logic [7:0] CH_LF     = 8'd10;
  localparam logic [7:0] CH_CR     = 8'd13;
  localparam logic [7:0] CH_HIGH   = 8'h80;

  // Telnet command codes
  localparam logic [7:0] CMD_EOF   = 8'd236;
  localparam logic [7:0] CMD_SUSP  = 8'd237;
  localparam logic [7:0] CMD_ABORT = 8'd238;
  localparam logic [7:0] CMD_EOR   = 8'd239;
  localparam logic [7:0] CMD_SE    = 8'd240;
  localparam logic [7:0] CMD_NOP   = 8'd241;
  localparam logic [7:0] CMD_DM    = 8'd242;
  localparam logic [7:0] CMD_BRK   = 8'd243;
  localparam logic [7:0] CMD_IP    = 8'd244;
  localparam logic [7:0] CMD_AO    = 8'd245;
  localparam logic [7:0] CMD_AYT   = 8'd246;
  localparam logic [7:0] CMD_EC    = 8'd247;
  localparam logic [7:0] CMD_EL    = 8'd248;
  localparam logic [7:0] CMD_GA    = 8'd249;
  localparam logic [7:0] CMD_SB    = 8'd250;
  localparam logic [7:0] CMD_WILL  = 8'd251;
  localparam logic [7:0] CMD_WONT  = 8'd252;
  localparam logic [7:0] CMD_DO    = 8'd253;
  localparam logic [7:0] CMD_DONT  = 8'd254;
  localparam logic [7:0] CMD_IAC   = 8'd255;

  localparam logic [7:0] OPT_ECHO  = 8'd1;

  // Parser modes
  typedef enum logic [2:0] {
    MODE_TEXT,
    MODE_CR,
    MODE_IAC,
    MODE_WILL,
    MODE_WONT,
    MODE_DO,
    MODE_SB,
    MODE_SBSE
  } mode_t;

  // Result actions
  typedef enum logic [1:0] {
    ACT_STORE,
    ACT_LINE,
    ACT_WONT,
    ACT_CMD
  } action_t;

  typedef struct packed {
    action_t            action;
    logic [POS_W-1:0]   position;
    logic [7:0]         value;
    logic               echo_on;
    logic               last;
  } result_t;

  // Up to two results produced by one byte
  typedef struct packed {
    logic [1:0] count;
    result_t    r0;
    result_t    r1;
  } pair_t;

  // Low nine bits of a length or column
  function automatic logic [POS_W-1:0] pos9(input logic [LEN_W-1:0] v);
    logic [LEN_W+POS_W-1:0] wide;
    wide = {{POS_W{1'b0}}, v};
    return wide[POS_W-1:0];
  endfunction

endpackage
`default_nettype wire

// ----- src/tnvt_decode.sv -----
// Parser state machine: mode, column and echo flag, and the results of one byte.
`timescale 1ns / 1ps
`default_nettype none
module tnvt_decode (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          step,
  input  wire logic [7:0]    ch,
  output tnvt_pkg::pair_t    pair
);
  import tnvt_pkg::*;

  mode_t            mode, mode_next;
  logic [COL_W-1:0] column, column_next;
  logic             echo_flag, echo_next;

  logic [LEN_W-1:0] col_ext;
  logic [LEN_W-1:0] col_inc;
  logic             col_nz;
  result_t          r0, r1;
  logic [1:0]       n;

  assign col_ext = LEN_W'(column);
  assign col_inc = col_ext + LEN_W'(1);
  assign col_nz  = (column != '0);

  // State registers, advanced once per processed byte
  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= MODE_TEXT;
      column    <= '0;
      echo_flag <= 1'b0;
    end else if (step) begin
      mode      <= mode_next;
      column    <= column_next;
      echo_flag <= echo_next;
    end
  end

  // Next state and results
  always_comb begin
    mode_next   = mode;
    column_next = column;
    echo_next   = echo_flag;
    n           = 2'd0;
    r0          = '0;
    r1          = '0;

    unique case (mode)
      MODE_TEXT: begin
        priority if (ch == CH_CR) begin
          mode_next = MODE_CR;
        end else if (ch == CMD_IAC) begin
          mode_next = MODE_IAC;
        end else if (ch == CH_LF) begin
          if (col_nz) begin
            r0.action   = ACT_LINE;
            r0.position = pos9(col_ext);
            n           = 2'd1;
          end
          column_next = '0;
        end else if (ch < CH_HIGH) begin
          r0.action   = ACT_STORE;
          r0.position = pos9(col_ext);
          r0.value    = ch;
          n           = 2'd1;
          if (col_inc == LEN_W'(LINE_LENGTH)) begin
            // line full: report it right after the char
            r1.action   = ACT_LINE;
            r1.position = pos9(LEN_W'(LINE_LENGTH));
            n           = 2'd2;
            column_next = '0;
          end else begin
            column_next = col_inc[COL_W-1:0];
          end
        end else begin
          // high bytes dropped
        end
      end

      MODE_CR: begin
        mode_next = MODE_TEXT;
        if (ch == CH_NUL || ch == CH_LF) begin
          if (col_nz) begin
            r0.action   = ACT_LINE;
            r0.position = pos9(col_ext);
            n           = 2'd1;
          end
          column_next = '0;
        end
      end

      MODE_IAC: begin
        mode_next = MODE_TEXT;
        unique case (ch)
          CMD_WILL: mode_next = MODE_WILL;
          CMD_WONT: mode_next = MODE_WONT;
          CMD_DO, CMD_DONT: mode_next = MODE_DO;
          CMD_SB: mode_next = MODE_SB;
          CMD_EC: begin
            if (col_nz) column_next = column - COL_W'(1);
          end
          CMD_EL, CMD_DM: column_next = '0;
          CMD_EOF, CMD_SUSP, CMD_ABORT, CMD_EOR, CMD_NOP,
          CMD_BRK, CMD_IP, CMD_AO, CMD_AYT, CMD_GA: begin
            // flush the pending line, then the notice
            column_next = '0;
            if (col_nz) begin
              r0.action   = ACT_LINE;
              r0.position = pos9(col_ext);
              r1.action   = ACT_CMD;
              r1.value    = ch;
              n           = 2'd2;
            end else begin
              r0.action   = ACT_CMD;
              r0.value    = ch;
              n           = 2'd1;
            end
          end
          default: ;
        endcase
      end

      MODE_WILL: begin
        if (ch == OPT_ECHO) echo_next = 1'b1;
        mode_next = MODE_TEXT;
      end

      MODE_WONT: begin
        if (ch == OPT_ECHO) echo_next = 1'b0;
        mode_next = MODE_TEXT;
      end

      MODE_DO: begin
        r0.action = ACT_WONT;
        r0.value  = ch;
        n         = 2'd1;
        mode_next = MODE_TEXT;
      end

      MODE_SB: begin
        if (ch == CMD_IAC) mode_next = MODE_SBSE;
      end

      MODE_SBSE: begin
        mode_next = (ch == CMD_SE) ? MODE_TEXT : MODE_SB;
      end

      default: mode_next = MODE_TEXT;
    endcase

    // Echo flag after this byte; mark the final result
    r0.echo_on = echo_next;
    r1.echo_on = echo_next;
    r0.last    = (n == 2'd1);
    r1.last    = (n == 2'd2);

    pair.count = n;
    pair.r0    = r0;
    pair.r1    = r1;
  end

endmodule
`default_nettype wire

// ----- src/tnvt_result_fifo.sv -----
// Result queue: takes up to two results per cycle, hands out one per beat.
`timescale 1ns / 1ps
`default_nettype none
module tnvt_result_fifo (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire tnvt_pkg::pair_t pair,
  output logic               space,
  output logic               out_valid,
  input  wire logic          out_ready,
  output tnvt_pkg::result_t  head_res
);
  import tnvt_pkg::*;

  result_t            mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] head, tail;
  logic [FIFO_CW-1:0] count;
  logic [FIFO_CW-1:0] push_n;
  logic               pop;

  // Room for a full pair
  assign space     = (count <= FIFO_CW'(FIFO_DEPTH - 2));
  assign out_valid = (count != '0);
  assign pop       = out_valid && out_ready;
  assign push_n    = push ? FIFO_CW'(pair.count) : '0;
  assign head_res  = mem[head];

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (pop) head <= head + FIFO_AW'(1);
      tail  <= tail + push_n[FIFO_AW-1:0];
      count <= count + push_n - FIFO_CW'(pop);
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push && pair.count != 2'd0) mem[tail] <= pair.r0;
    if (push && pair.count == 2'd2) mem[tail + FIFO_AW'(1)] <= pair.r1;
  end

endmodule
`default_nettype wire

// ----- src/telnet_nvt_receive_parser.sv -----
// Top level of the telnet NVT receive parser: input register, decoder, result queue.
`timescale 1ns / 1ps
`default_nettype none
// One received telnet byte per input beat; each byte yields zero, one or two
// result beats (store char, line ready, WONT request, command notice), the
// final one flagged by last. A byte waits in the input register until the
// queue has room, is decoded in a single pass against the parse mode, column
// and echo flag, and its results go into a four-entry queue. A new byte is
// taken every cycle while the queue has room for a pair; output beats drain
// one per cycle while out_ready is high. On its way to the first result beat
// a byte passes the input register and then the queue.
module telnet_nvt_receive_parser (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] rx_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [1:0]      action,
  output logic [8:0]      position,
  output logic [7:0]      value,
  output logic            echo_on,
  output logic            last
);
  import tnvt_pkg::*;

  logic       in_full;
  logic [7:0] in_byte;
  logic       space;
  logic       proceed;
  pair_t      pair;
  result_t    head_res;

  assign proceed  = in_full && space;
  assign in_ready = !in_full || proceed;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_full <= 1'b1;
    end else if (proceed) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) in_byte <= rx_byte;
  end

  tnvt_decode u_decode (
    .clk  (clk),
    .rst  (rst),
    .step (proceed),
    .ch   (in_byte),
    .pair (pair)
  );

  tnvt_result_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (proceed),
    .pair      (pair),
    .space     (space),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head_res  (head_res)
  );

  // Result beat fields
  assign action   = head_res.action;
  assign position = head_res.position;
  assign value    = head_res.value;
  assign echo_on  = head_res.echo_on;
  assign last     = head_res.last;

endmodule
`default_nettype wire
